// ===== rtl/sosc_pkg.sv =====
// Shared types and constants for the stack output sequence check.
`default_nettype none
package sosc_pkg;

  // Width of one sequence element
  localparam int unsigned VALUE_W = 8;

  // State held by one compare cell
  typedef struct packed {
    logic               occupied;
    logic               have_prev;
    logic [VALUE_W-1:0] prev;
    logic [VALUE_W-1:0] pivot;
  } cell_t;

endpackage
`default_nettype wire

// ===== rtl/sosc_cell.sv =====
// One compare cell of the chain: holds one stored element and its watch state.
`default_nettype none
module sosc_cell (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         advance,   // an element is taken into the chain
  input  wire                         clear,     // discard the stored sequence
  input  wire [sosc_pkg::VALUE_W-1:0] value,     // arriving element
  input  sosc_pkg::cell_t             up_state,  // updated state of the upstream cell
  output sosc_pkg::cell_t             upd_state, // own state after seeing the arrival
  output logic                        bad        // arrival breaks the order rule
);
  import sosc_pkg::*;

  cell_t state;

  // Compare the arrival against the stored pivot
  logic below;
  assign below = state.occupied && (value < state.pivot);
  assign bad   = advance && below && state.have_prev && (state.prev < value);

  // Track the last smaller element seen after the pivot
  always_comb begin
    upd_state = state;
    if (below) begin
      upd_state.prev      = value;
      upd_state.have_prev = 1'b1;
    end
  end

  // Take the upstream state whenever an element advances into the chain
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state.occupied <= 1'b0;
    end else if (advance) begin
      state.occupied <= up_state.occupied;
    end
    if (advance) begin
      state.have_prev <= up_state.have_prev;
      state.prev      <= up_state.prev;
      state.pivot     <= up_state.pivot;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stack_output_sequence_check_top.sv =====
// Top level of the stack output sequence check: cell chain, counters and result stage.
`default_nettype none
// Takes one element per beat on the slave side, with tlast on the final element, and
// tells whether the sequence is a legal stack pop order (no 312 pattern). One element is
// accepted every clock cycle unless two results wait: a chain of MAX_LEN compare cells
// shifts the stored elements along by one per beat, and every cell compares the arriving
// element against its own stored value in that same cycle. The result of the tlast beat
// is registered into the output register that drives the master side, or into the
// one-deep skid stage while that output is held; the two let input beats keep flowing
// while one result waits, and the input stalls once two results wait. Elements beyond
// MAX_LEN are dropped, and such a sequence reports overflowed and not legal.
module stack_output_sequence_check_top #(
  parameter int unsigned MAX_LEN = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] element_value
  input  wire        s_tlast,   // is_last
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata    // [0] is_legal, [1] overflowed, [7:2] zero
);
  import sosc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

  logic [CNT_W-1:0] count;
  logic             overflow_seen;
  logic             bad_seen;

  logic             in_fire;
  logic             full;
  logic             advance;
  logic             clear;

  assign in_fire = s_tvalid && s_tready;
  assign full    = (count == FULL);
  assign advance = in_fire && !full;
  assign clear   = in_fire && s_tlast;

  // Build the chain of compare cells
  cell_t            up   [MAX_LEN];
  cell_t            upd  [MAX_LEN];
  logic [MAX_LEN-1:0] cell_bad;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
      if (gi > 0) begin : g_link
        assign up[gi] = upd[gi-1];
      end else begin : g_head
        // Feed the arriving element into the head of the chain
        assign up[gi] = '{occupied: 1'b1, have_prev: 1'b0, prev: '0,
                          pivot: s_tdata[VALUE_W-1:0]};
      end
      sosc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .clear     (clear),
        .value     (s_tdata[VALUE_W-1:0]),
        .up_state  (up[gi]),
        .upd_state (upd[gi]),
        .bad       (cell_bad[gi])
      );
    end
  endgenerate

  logic bad_now;
  logic ovf_now;
  assign bad_now = |cell_bad;
  assign ovf_now = in_fire && full;

  // Count elements and hold sticky flags for the current sequence
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      bad_seen      <= 1'b0;
    end else begin
      if (advance) begin
        count <= count + CNT_W'(1);
      end
      if (ovf_now) begin
        overflow_seen <= 1'b1;
      end
      if (bad_now) begin
        bad_seen <= 1'b1;
      end
    end
  end

  // Form the result of the sequence that ends on this beat
  logic [1:0] res;
  logic       res_ovf;
  assign res_ovf = overflow_seen || ovf_now;
  assign res     = {res_ovf, !res_ovf && !bad_seen && !bad_now};

  // Output register with one-deep skid stage
  logic       out_valid;
  logic [1:0] out_data;
  logic       skid_valid;
  logic [1:0] skid_data;

  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (clear) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= clear;
    end else begin
      out_valid  <= clear;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_tready) begin
      if (clear) begin
        skid_data <= res;
      end
    end else if (skid_valid) begin
      out_data  <= skid_data;
      skid_data <= res;
    end else begin
      out_data  <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_data};

  // Checks on the internal logic
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("element count exceeds capacity");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    clear |=> (count == '0) && !overflow_seen && !bad_seen)
    else $error("sequence state not discarded after the final beat");

  a_ovf_not_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data[1] && out_data[0]))
    else $error("overflowed sequence reported as legal");

endmodule
`default_nettype wire

// ===== tb/sv/tb_stack_output_sequence_check_top.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the stack output sequence check top level.
module tb_stack_output_sequence_check_top;
  import sosc_pkg::*;

  localparam int unsigned MAX_LEN      = 32;
  localparam int          TAIL_CYCLES  = 12;
  localparam int          QUIET_FROM   = 300;
  localparam int          QUIET_TO     = 700;
  localparam int          HOLD_AFTER   = 15;
  localparam int          HOLD_CYCLES  = 160;
  localparam int          RANDOM_ITEMS = 450;
  localparam int          GAP_PERCENT  = 27;
  localparam int          REPORT_LIMIT = 10;

  // Result byte as it sits on m_tdata, lowest bit last in the list
  typedef struct packed {
    logic [5:0] pad;
    logic       overflowed;
    logic       is_legal;
  } verdict_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    bit                 drain;
  } element_beat_t;

  typedef enum int {SEQ_POP_ORDER, SEQ_BROKEN_ORDER, SEQ_NOISE} seq_kind_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata  = '0;   // [7:0] element_value
  logic               s_tlast  = 1'b0; // is_last
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;         // [0] is_legal, [1] overflowed, [7:2] zero

  // Pending input beats and outstanding verdicts
  element_beat_t      feed[$];
  logic [VALUE_W-1:0] build_q[$];
  verdict_t           verdict_q[$];
  int                 open_results = 0;
  int                 results_seen = 0;
  int                 fail_count   = 0;

  // Predictor state: the elements held for the current sequence
  logic [VALUE_W-1:0] held_vals[MAX_LEN];
  int                 held_count;
  bit                 held_ovf;

  int unsigned        cyc;
  int                 hold_left;
  bit                 hold_done;

  stack_output_sequence_check_top #(.MAX_LEN(MAX_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // No later held element below a pivot may rise over an earlier one
  function automatic bit stack_order_ok();
    bit                 seen;
    logic [VALUE_W-1:0] prev;
    for (int i = 0; i < held_count; i++) begin
      seen = 1'b0;
      prev = '0;
      for (int k = i + 1; k < held_count; k++) begin
        if (held_vals[k] < held_vals[i]) begin
          if (seen && prev < held_vals[k]) return 1'b0;
          prev = held_vals[k];
          seen = 1'b1;
        end
      end
    end
    return 1'b1;
  endfunction

  // Take one element; on the last one hand back the verdict and start afresh
  task automatic absorb_element(input logic [VALUE_W-1:0] v, input logic last,
                                output bit produced, output verdict_t res);
    produced = 1'b0;
    res      = '0;
    if (held_count < MAX_LEN) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      res.is_legal   = !held_ovf && stack_order_ok();
      res.overflowed = held_ovf;
      produced       = 1'b1;
      held_count     = 0;
      held_ovf       = 1'b0;
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
  endtask

  // Move the built sequence into the feed, tlast on its final element
  task automatic commit_sequence(input bit drain_first);
    element_beat_t beat;
    for (int i = 0; i < build_q.size(); i++) begin
      beat.value = build_q[i];
      beat.last  = (i == build_q.size() - 1);
      beat.drain = drain_first && (i == 0);
      feed.push_back(beat);
    end
    build_q.delete();
  endtask

  // Push ascending values and pop at random: always a legal order
  task automatic make_pop_order(input int n);
    logic [VALUE_W-1:0] asc[$];
    logic [VALUE_W-1:0] pile[$];
    int                 level;
    int                 step_max;
    int                 push_idx;
    level    = $urandom_range(0, 64);
    step_max = (255 - level) / n;
    for (int i = 0; i < n; i++) begin
      level += $urandom_range(0, step_max);
      asc.push_back(level[VALUE_W-1:0]);
    end
    push_idx = 0;
    while (build_q.size() < n) begin
      if (pile.size() == 0 || (push_idx < n && $urandom_range(0, 1) == 1)) begin
        pile.push_back(asc[push_idx]);
        push_idx++;
      end else begin
        build_q.push_back(pile.pop_back());
      end
    end
  endtask

  function automatic bit take_gap();
    return !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(0, 99) < GAP_PERCENT);
  endfunction

  // Count cycles since reset
  always @(posedge clk) begin
    if (rst) cyc <= 0;
    else cyc <= cyc + 1;
  end

  // Hold the receiver off once for a long stretch after the first results
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Drive element beats from the feed; a drain beat waits for every verdict
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (feed.size() != 0 && !take_gap() &&
          !(feed[0].drain && (s_tvalid || open_results != 0))) begin
        s_tvalid <= 1'b1;
        s_tdata  <= feed[0].value;
        s_tlast  <= feed[0].last;
        void'(feed.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, stalled at random or for the long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_left != 0) m_tready <= 1'b0;
    else m_tready <= !take_gap();
  end

  // Check result beats, then predict from the element beat of this edge
  always @(posedge clk) begin : verdict_watch
    verdict_t got;
    verdict_t want;
    verdict_t fresh;
    bit       produced;
    int       change;
    if (rst) begin
      held_count = 0;
      held_ovf   = 1'b0;
    end else begin
      change = 0;
      if (m_tvalid && m_tready) begin
        got = verdict_t'(m_tdata);
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("result beat with none pending: tdata=%02h", m_tdata));
        end else begin
          want = verdict_q.pop_front();
          change--;
          if (got.is_legal !== want.is_legal || got.overflowed !== want.overflowed ||
              got.pad !== want.pad)
            note_failure($sformatf(
              "verdict mismatch: is_legal exp %0b got %0b, overflowed exp %0b got %0b, pad got %02h",
              want.is_legal, got.is_legal, want.overflowed, got.overflowed, got.pad));
        end
        results_seen <= results_seen + 1;
      end
      if (s_tvalid && s_tready) begin
        absorb_element(s_tdata, s_tlast, produced, fresh);
        if (produced) begin
          verdict_q.push_back(fresh);
          change++;
        end
      end
      open_results <= open_results + change;
    end
  end

  // Build the stimulus, release reset, wait for the last verdict
  initial begin : run_control
    int        random_count;
    int        seq_idx;
    int        n;
    int        pick;
    int        a;
    int        b;
    seq_kind_t kind;
    logic [VALUE_W-1:0] swap_val;

    // Directed: single elements, rises, the forbidden pattern, repeats, extremes
    build_q = '{8'd0};                           commit_sequence(1'b0);
    build_q = '{8'd255};                         commit_sequence(1'b0);
    build_q = '{8'd1, 8'd2, 8'd3};               commit_sequence(1'b0);
    build_q = '{8'd3, 8'd1, 8'd2};               commit_sequence(1'b0);
    build_q = '{8'd3, 8'd2, 8'd1};               commit_sequence(1'b0);
    build_q = '{8'd2, 8'd2, 8'd1, 8'd1};         commit_sequence(1'b0);
    build_q = '{8'd255, 8'd0, 8'd128};           commit_sequence(1'b0);
    build_q = '{8'd0, 8'd255, 8'd255, 8'd0};     commit_sequence(1'b0);
    build_q = '{8'd170, 8'd85};                  commit_sequence(1'b0);

    // Random: mostly legal pop orders, some broken ones, some noise
    random_count = 0;
    seq_idx      = 0;
    while (random_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (seq_idx == 1) n = MAX_LEN + 1;
      else if (seq_idx == 2) n = MAX_LEN;
      else if (pick < 85) n = $urandom_range(1, 10);
      else if (pick < 95) n = $urandom_range(11, MAX_LEN - 1);
      else n = $urandom_range(MAX_LEN, MAX_LEN + 8);

      pick = $urandom_range(0, 99);
      if (seq_idx <= 2 || pick < 55) kind = SEQ_POP_ORDER;
      else if (pick < 75) kind = SEQ_BROKEN_ORDER;
      else kind = SEQ_NOISE;

      case (kind)
        SEQ_POP_ORDER: begin
          make_pop_order(n);
        end
        SEQ_BROKEN_ORDER: begin
          make_pop_order(n);
          if (n >= 2) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            swap_val   = build_q[a];
            build_q[a] = build_q[b];
            build_q[b] = swap_val;
          end
        end
        default: begin
          for (int i = 0; i < n; i++) build_q.push_back(VALUE_W'($urandom_range(0, 255)));
        end
      endcase
      commit_sequence(seq_idx == 0 || $urandom_range(0, 99) < 4);
      random_count += n;
      seq_idx++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (feed.size() != 0 || s_tvalid || open_results != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("stack_output_sequence_check_top regression: pass");
    end else begin
      $display("stack_output_sequence_check_top regression: fail");
    end
    $finish;
  end

  // Give up well beyond the slowest correct run
  initial begin : watchdog
    #4_000_000;
    $display("stack_output_sequence_check_top regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sosc_pkg.sv
rtl/sosc_cell.sv
rtl/stack_output_sequence_check_top.sv
tb/sv/tb_stack_output_sequence_check_top.sv
